>>> sv/kpsd_pkg.sv
// Package for the keypad scanner with press debounce.
// Holds matrix sizes, field widths, reset values and the result type.
// No dependencies.
package kpsd_pkg;

  localparam int MATRIX_DIM = 4;
  localparam int KEY_COUNT  = MATRIX_DIM * MATRIX_DIM;
  localparam int ROW_W      = $clog2(MATRIX_DIM);
  localparam int COL_W      = 4;
  localparam int IDX_W      = 4;
  localparam int THR_W      = 16;

  localparam logic [THR_W-1:0]     THRESH_RESET = 16'd256;
  localparam logic [THR_W-1:0]     COUNT_MAX    = 16'hFFFF;
  localparam logic [KEY_COUNT-1:0] KEYS_ALL     = {KEY_COUNT{1'b1}};

  typedef struct packed {
    logic [COL_W-1:0] row_drive;
    logic             press_valid;
    logic [IDX_W-1:0] key_index;
  } kpsd_res_t;

  // index of the lowest set bit; zero when none is set
  function automatic logic [IDX_W-1:0] lowest_set(input logic [KEY_COUNT-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> sv/keypad_scan_press_debounce.sv
// Top level of the keypad scanner: row sequencing, scan mask, debounce, output buffer.
// Depends on kpsd_pkg.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_column_levels
//   out_    | output    | out_valid / out_stall| out_row_drive, out_press_valid, out_key_index
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_data (press threshold)
//
// One transaction per cycle while in_stall is low; each input transaction yields one
// result transaction from a single pass of mask and count logic between state registers
// and the output buffer, written into its register or skid entry. A two-entry output
// buffer (register plus skid) keeps input flowing while a result waits; in_stall rises
// only when both entries are full. Synchronous active-low reset; cfg_ready is always high.
module keypad_scan_press_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kpsd_pkg::COL_W-1:0]    in_column_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kpsd_pkg::COL_W-1:0]    out_row_drive,
  output logic                          out_press_valid,
  output logic [kpsd_pkg::IDX_W-1:0]    out_key_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpsd_pkg::THR_W-1:0]    cfg_data
);
  import kpsd_pkg::*;

  logic [THR_W-1:0]     thresh_r;
  logic [ROW_W-1:0]     row_r,        row_nxt;
  logic [KEY_COUNT-1:0] scan_r,       scan_nxt;
  logic [KEY_COUNT-1:0] remem_r,      remem_nxt;
  logic                 cand_valid_r, cand_valid_nxt;
  logic [IDX_W-1:0]     cand_idx_r,   cand_idx_nxt;
  logic [THR_W-1:0]     count_r,      count_nxt;

  kpsd_res_t res_nxt;
  kpsd_res_t main_r, skid_r;
  logic      main_valid_r, skid_valid_r;

  logic                 in_accept, out_take;
  logic [KEY_COUNT-1:0] row_bits, fresh, remem_and, pressed;
  logic [IDX_W-1:0]     new_idx;
  logic                 last_row;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = main_valid_r && !out_stall;

  assign out_valid       = main_valid_r;
  assign out_row_drive   = main_r.row_drive;
  assign out_press_valid = main_r.press_valid;
  assign out_key_index   = main_r.key_index;

  always_comb begin
    row_bits = '0;
    for (int c = 0; c < MATRIX_DIM; c++) begin
      if (!in_column_levels[c]) begin
        row_bits[c * MATRIX_DIM + (MATRIX_DIM - 1) - int'(row_r)] = 1'b1;
      end
    end
  end

  assign last_row  = (row_r == ROW_W'(MATRIX_DIM - 1));
  assign fresh     = scan_r | row_bits;
  assign remem_and = remem_r & fresh;
  assign pressed   = fresh & ~remem_and;
  assign new_idx   = lowest_set(pressed);

  always_comb begin
    row_nxt        = row_r;
    scan_nxt       = scan_r;
    remem_nxt      = remem_r;
    cand_valid_nxt = cand_valid_r;
    cand_idx_nxt   = cand_idx_r;
    count_nxt      = count_r;
    res_nxt.press_valid = 1'b0;
    res_nxt.key_index   = '0;
    if (!last_row) begin
      row_nxt  = row_r + 1'b1;
      scan_nxt = fresh;
    end else begin
      row_nxt   = '0;
      scan_nxt  = '0;
      remem_nxt = remem_and;
      if (|pressed) begin
        if (cand_valid_r && cand_idx_r == new_idx) begin
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          count_nxt = '0;
        end
        cand_valid_nxt = 1'b1;
        cand_idx_nxt   = new_idx;
      end else begin
        cand_valid_nxt = 1'b0;
        cand_idx_nxt   = '0;
        count_nxt      = '0;
      end
      if (cand_valid_nxt && count_nxt >= thresh_r) begin
        res_nxt.press_valid = 1'b1;
        res_nxt.key_index   = cand_idx_nxt;
        remem_nxt      = KEYS_ALL;
        cand_valid_nxt = 1'b0;
        cand_idx_nxt   = '0;
        count_nxt      = '0;
      end
    end
    for (int r = 0; r < COL_W; r++) begin
      res_nxt.row_drive[r] = (int'(row_nxt) != r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= THRESH_RESET;
      row_r        <= '0;
      scan_r       <= '0;
      remem_r      <= KEYS_ALL;
      cand_valid_r <= 1'b0;
      cand_idx_r   <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
      if (in_accept) begin
        row_r        <= row_nxt;
        scan_r       <= scan_nxt;
        remem_r      <= remem_nxt;
        cand_valid_r <= cand_valid_nxt;
        cand_idx_r   <= cand_idx_nxt;
        count_r      <= count_nxt;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid_r) begin
          main_r       <= skid_r;
          skid_valid_r <= 1'b0;
        end else if (in_accept) begin
          main_r <= res_nxt;
        end else begin
          main_valid_r <= 1'b0;
        end
      end else if (in_accept) begin
        if (!main_valid_r) begin
          main_r       <= res_nxt;
          main_valid_r <= 1'b1;
        end else begin
          skid_r       <= res_nxt;
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

endmodule
